// File: design/psd_pkg.sv
// Shared types and constants for the point-to-segment distance block.
// Depends on nothing; every other design file imports it.
`timescale 1ns / 1ps
package psd_pkg;

	// Default coordinate width. Q16.16 inputs; the fraction position does not
	// change any of the integer arithmetic.
	localparam int COORD_WIDTH_DEF = 32;

	// Which part of the segment is closest to the query point.
	typedef enum logic [1:0] {
		REGION_START    = 2'd0,
		REGION_END      = 2'd1,
		REGION_INTERIOR = 2'd2
	} region_t;

	// Control that travels with every request down the pipeline and the cells.
	typedef struct packed {
		logic    valid;
		region_t region;
		logic    degen;
	} psd_ctl_t;

endpackage

// File: design/psd_front.sv
// Front end of the distance pipeline: differences, products, sums, region choice,
// and the numerator/denominator pair handed to the divider cells. Uses psd_pkg.
`timescale 1ns / 1ps
module psd_front import psd_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [CW-1:0] pt [3],
	input  logic signed [CW-1:0] st [3],
	input  logic signed [CW-1:0] ed [3],
	output psd_ctl_t             ctl_o,
	output logic [4*CW+3:0]      num_o,
	output logic [2*CW+1:0]      den_o
);
	localparam int DW  = CW + 1;
	localparam int PW  = 2 * DW;
	localparam int HW  = DW;
	localparam int SW  = PW;
	localparam int DTW = PW + 1;
	localparam int NW  = 2 * PW;

	logic signed [DW-1:0]  d_s1 [3], w_s1 [3], e_s1 [3];
	logic                  v_s1, v_s2, v_s3;
	logic signed [PW-1:0]  dsq_s2 [3], wsq_s2 [3], esq_s2 [3], dot_s2 [3];
	logic signed [PW-1:0]  cpa_s2 [3], cpb_s2 [3];
	logic [SW-1:0]         dd_s3, ww_s3, ee_s3;
	logic signed [DTW-1:0] dot_s3;
	logic signed [PW-1:0]  cr_s3 [3];
	logic [PW-1:0]         mag [3];
	logic [PW-1:0]         hh_s4 [3], hl_s4 [3], ll_s4 [3];
	logic [SW-1:0]         dd_s4, ww_s4, ee_s4, dd_s5, ww_s5, ee_s5;
	logic [NW-1:0]         xsq_s5 [3];
	psd_ctl_t              ctl_s4, ctl_s5, ctl_s6, ctl_n;
	logic [NW-1:0]         num_s6;
	logic [SW-1:0]         den_s6;

	// Valid bits and control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else if (en) begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			ctl_s4 <= ctl_n;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
		end
	end

	// A zero-length segment, the sign of the dot product and its size against |d|^2 pick the region.
	always_comb begin
		ctl_n.valid  = v_s3;
		ctl_n.degen  = (dd_s3 == '0);
		ctl_n.region = REGION_INTERIOR;
		if (ctl_n.degen || dot_s3[DTW-1]) begin
			ctl_n.region = REGION_START;
		end else if (dot_s3 > $signed({1'b0, dd_s3})) begin
			ctl_n.region = REGION_END;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = cr_s3[i][PW-1] ? PW'(-cr_s3[i]) : PW'(cr_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]   <= DW'(ed[i]) - DW'(st[i]);
				w_s1[i]   <= DW'(pt[i]) - DW'(st[i]);
				e_s1[i]   <= DW'(pt[i]) - DW'(ed[i]);
				dsq_s2[i] <= d_s1[i] * d_s1[i];
				wsq_s2[i] <= w_s1[i] * w_s1[i];
				esq_s2[i] <= e_s1[i] * e_s1[i];
				dot_s2[i] <= w_s1[i] * d_s1[i];
				cpa_s2[i] <= w_s1[(i + 1) % 3] * d_s1[(i + 2) % 3];
				cpb_s2[i] <= w_s1[(i + 2) % 3] * d_s1[(i + 1) % 3];
				cr_s3[i]  <= cpa_s2[i] - cpb_s2[i];
				// Square of a cross component, split into half-width products.
				hh_s4[i]  <= mag[i][PW-1:HW] * mag[i][PW-1:HW];
				hl_s4[i]  <= mag[i][PW-1:HW] * mag[i][HW-1:0];
				ll_s4[i]  <= mag[i][HW-1:0] * mag[i][HW-1:0];
				xsq_s5[i] <= (NW'(hh_s4[i]) << (2 * HW)) + (NW'(hl_s4[i]) << (HW + 1))
					+ NW'(ll_s4[i]);
			end
			dd_s3  <= $unsigned(dsq_s2[0]) + $unsigned(dsq_s2[1]) + $unsigned(dsq_s2[2]);
			ww_s3  <= $unsigned(wsq_s2[0]) + $unsigned(wsq_s2[1]) + $unsigned(wsq_s2[2]);
			ee_s3  <= $unsigned(esq_s2[0]) + $unsigned(esq_s2[1]) + $unsigned(esq_s2[2]);
			dot_s3 <= DTW'(dot_s2[0]) + DTW'(dot_s2[1]) + DTW'(dot_s2[2]);
			dd_s4  <= dd_s3;
			ww_s4  <= ww_s3;
			ee_s4  <= ee_s3;
			dd_s5  <= dd_s4;
			ww_s5  <= ww_s4;
			ee_s5  <= ee_s4;
			// |w x d|^2 equals |w|^2 |d|^2 - dot^2, so the interior case is
			// |w x d|^2 / |d|^2; the end cases divide by one.
			case (ctl_s5.region)
				REGION_INTERIOR: begin
					num_s6 <= xsq_s5[0] + xsq_s5[1] + xsq_s5[2];
					den_s6 <= dd_s5;
				end
				REGION_END: begin
					num_s6 <= NW'(ee_s5);
					den_s6 <= SW'(1);
				end
				default: begin
					num_s6 <= NW'(ww_s5);
					den_s6 <= SW'(1);
				end
			endcase
		end
	end

	assign ctl_o = ctl_s6;
	assign num_o = num_s6;
	assign den_o = den_s6;

endmodule

// File: design/psd_div_cell.sv
// One restoring-division cell: brings down one numerator bit and yields one
// quotient bit. Uses psd_pkg for the control struct.
`timescale 1ns / 1ps
module psd_div_cell import psd_pkg::*; #(
	parameter int W = 2 * COORD_WIDTH_DEF + 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  psd_ctl_t       ctl_i,
	input  logic [W-1:0]   rem_i,
	input  logic [W-1:0]   nq_i,
	input  logic [W-1:0]   den_i,
	output psd_ctl_t       ctl_o,
	output logic [W-1:0]   rem_o,
	output logic [W-1:0]   nq_o,
	output logic [W-1:0]   den_o
);
	logic [W:0]   trial, diff;
	logic         ge;
	psd_ctl_t     ctl_q;
	logic [W-1:0] rem_q, nq_q, den_q;

	// The remainder stays below the divisor, so W bits hold it after the step.
	assign trial = {rem_i, nq_i[W-1]};
	assign diff  = trial - {1'b0, den_i};
	assign ge    = (trial >= {1'b0, den_i});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	// Numerator bits leave at the top of nq while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			nq_q  <= {nq_i[W-2:0], ge};
			den_q <= den_i;
		end
	end

	assign ctl_o = ctl_q;
	assign rem_o = rem_q;
	assign nq_o  = nq_q;
	assign den_o = den_q;

endmodule

// File: design/psd_sqrt_cell.sv
// One digit-by-digit square-root cell: takes two radicand bits and yields one
// root bit. Uses psd_pkg for the control struct.
`timescale 1ns / 1ps
module psd_sqrt_cell import psd_pkg::*; #(
	parameter int RW = COORD_WIDTH_DEF + 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  psd_ctl_t        ctl_i,
	input  logic [2*RW-1:0] rad_i,
	input  logic [RW:0]     rem_i,
	input  logic [RW-1:0]   root_i,
	output psd_ctl_t        ctl_o,
	output logic [2*RW-1:0] rad_o,
	output logic [RW:0]     rem_o,
	output logic [RW-1:0]   root_o
);
	logic [RW+2:0]   cur, trial, diff;
	logic            ge;
	psd_ctl_t        ctl_q;
	logic [2*RW-1:0] rad_q;
	logic [RW:0]     rem_q;
	logic [RW-1:0]   root_q;

	assign cur   = {rem_i, rad_i[2*RW-1:2*RW-2]};
	assign trial = {1'b0, root_i, 2'b01};
	assign diff  = cur - trial;
	assign ge    = (cur >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	// The remainder never exceeds twice the partial root, so RW+1 bits suffice.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? diff[RW:0] : cur[RW:0];
			root_q <= {root_i[RW-2:0], ge};
			rad_q  <= {rad_i[2*RW-3:0], 2'b00};
		end
	end

	assign ctl_o  = ctl_q;
	assign rad_o  = rad_q;
	assign rem_o  = rem_q;
	assign root_o = root_q;

endmodule

// File: design/point_segment_distance_3d.sv
// Point-to-segment distance in 3D. Each request carries a query point and the two
// end points of a segment in signed fixed point (Q16.16 by default) and returns the
// floor of the exact Euclidean distance as unsigned Q18.16, which region of the
// segment is closest, and a flag for a zero-length segment (then the start is used).
// The block accepts one request every clock cycle while in_ready is high, returns
// results in the order of acceptance, and moves each request through six front
// stages for differences, products and sums, a chain of 2*COORD_WIDTH+2 division
// cells (one quotient bit each), a chain of COORD_WIDTH+1 square-root cells (one
// root bit each), and the output register. A skid register behind the output holds
// one finished result when the consumer stalls; while it is full the whole chain
// holds and in_ready is low. in_ready is a register output and does not depend on
// out_ready in the same cycle. Depends on psd_pkg, psd_front and the two cell modules.
`timescale 1ns / 1ps
module point_segment_distance_3d import psd_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] start_z,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	input  logic signed [COORD_WIDTH-1:0] end_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [COORD_WIDTH+1:0]        distance,
	output logic [1:0]                    region,
	output logic                          degenerate
);
	// Quotient width; the quotient never exceeds |w|^2, which fits these bits.
	localparam int SW = 2 * COORD_WIDTH + 2;
	// Root width.
	localparam int RW = SW / 2;
	localparam int DISTW = COORD_WIDTH + 2;

	logic signed [COORD_WIDTH-1:0] pt [3], st [3], ed [3];
	logic                          en;

	psd_ctl_t      dctl [SW+1];
	logic [SW-1:0] drem [SW+1];
	logic [SW-1:0] dnq  [SW+1];
	logic [SW-1:0] dden [SW+1];
	logic [2*SW-1:0] num;

	psd_ctl_t      sctl  [RW+1];
	logic [SW-1:0] srad  [RW+1];
	logic [RW:0]   srem  [RW+1];
	logic [RW-1:0] sroot [RW+1];

	psd_ctl_t         out_ctl_q, skid_ctl_q;
	logic [DISTW-1:0] out_dist_q, skid_dist_q;
	logic             take, arrive, out_free;

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;
	assign st[0] = start_x;
	assign st[1] = start_y;
	assign st[2] = start_z;
	assign ed[0] = end_x;
	assign ed[1] = end_y;
	assign ed[2] = end_z;

	// The chain moves whenever the skid register is empty.
	assign en       = !skid_ctl_q.valid;
	assign in_ready = en;

	psd_front #(.CW(COORD_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.pt       (pt),
		.st       (st),
		.ed       (ed),
		.ctl_o    (dctl[0]),
		.num_o    (num),
		.den_o    (dden[0])
	);

	// The upper half of the numerator is already below the divisor, since the
	// quotient fits SW bits; the lower half is shifted in one bit per cell.
	assign drem[0] = num[2*SW-1:SW];
	assign dnq[0]  = num[SW-1:0];

	for (genvar k = 0; k < SW; k++) begin : g_div
		psd_div_cell #(.W(SW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  (dctl[k]),
			.rem_i  (drem[k]),
			.nq_i   (dnq[k]),
			.den_i  (dden[k]),
			.ctl_o  (dctl[k+1]),
			.rem_o  (drem[k+1]),
			.nq_o   (dnq[k+1]),
			.den_o  (dden[k+1])
		);
	end

	// The square root of the floored quotient equals the floor of the exact root.
	assign sctl[0]  = dctl[SW];
	assign srad[0]  = dnq[SW];
	assign srem[0]  = '0;
	assign sroot[0] = '0;

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		psd_sqrt_cell #(.RW(RW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  (sctl[k]),
			.rad_i  (srad[k]),
			.rem_i  (srem[k]),
			.root_i (sroot[k]),
			.ctl_o  (sctl[k+1]),
			.rad_o  (srad[k+1]),
			.rem_o  (srem[k+1]),
			.root_o (sroot[k+1])
		);
	end

	// Output register with a one-entry skid behind it.
	assign take     = out_ctl_q.valid && out_ready;
	assign arrive   = en && sctl[RW].valid;
	assign out_free = !out_ctl_q.valid || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ctl_q   <= '0;
			skid_ctl_q  <= '0;
			out_dist_q  <= '0;
			skid_dist_q <= '0;
		end else if (skid_ctl_q.valid) begin
			if (take) begin
				out_ctl_q        <= skid_ctl_q;
				out_dist_q       <= skid_dist_q;
				skid_ctl_q.valid <= 1'b0;
			end
		end else if (out_free) begin
			out_ctl_q.valid  <= arrive;
			out_ctl_q.region <= sctl[RW].region;
			out_ctl_q.degen  <= sctl[RW].degen;
			out_dist_q       <= {1'b0, sroot[RW]};
		end else begin
			skid_ctl_q.valid  <= arrive;
			skid_ctl_q.region <= sctl[RW].region;
			skid_ctl_q.degen  <= sctl[RW].degen;
			skid_dist_q       <= {1'b0, sroot[RW]};
		end
	end

	assign out_valid  = out_ctl_q.valid;
	assign distance   = out_dist_q;
	assign region     = out_ctl_q.region;
	assign degenerate = out_ctl_q.degen;

endmodule

// File: design/psd_checker.sv
// Port-level checks for point_segment_distance_3d, attached by a bind statement.
// Depends on psd_pkg for the region codes.
`timescale 1ns / 1ps
module psd_checker import psd_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [COORD_WIDTH+1:0] distance,
	input logic [1:0]             region,
	input logic                   degenerate
);
	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(distance) && $stable(region)
			&& $stable(degenerate))
		else $error("result changed while stalled");

	// A zero-length segment always reports the start as closest.
	a_degen_region: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> region == REGION_START)
		else $error("degenerate segment with a region other than start");

	// Back-pressure only happens when a result is waiting at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	// Once the waiting result is taken, requests flow again on the next cycle.
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && out_valid && out_ready |=> in_ready)
		else $error("input still stalled after the output drained");

endmodule

bind point_segment_distance_3d psd_checker #(.COORD_WIDTH(COORD_WIDTH)) u_psd_checker (.*);
